[rtl/core/mbe_pkg.sv]
package mbe_pkg;

  // Number format: signed Q8.FRAC_BITS.
  localparam int FRAC_BITS = 24;
  localparam int W         = FRAC_BITS + 8;
  localparam int PROD_W    = 2 * W;
  localparam int SQ_W      = PROD_W - FRAC_BITS;

  // Configuration register indexes and reset values.
  localparam logic [7:0] CFG_ITER_LIMIT   = 8'd0;
  localparam logic [7:0] CFG_RADIUS_SQ    = 8'd1;
  localparam logic [7:0] ITER_LIMIT_RESET = 8'd250;
  localparam logic [6:0] RADIUS_SQ_RESET  = 7'd100;

  // Display glyphs.
  localparam logic [6:0] GLYPH_SPACE = 7'd32;
  localparam logic [6:0] GLYPH_BASE  = 7'd97;

  // Division of an escape count by ten: (n * 205) >> 11 is exact for n below 1024.
  localparam logic [7:0] TENS_RECIP = 8'd205;
  localparam int         TENS_SHIFT = 11;

  // Point mapping. A scaled offset k * 2^FRAC_BITS / d splits into
  // k * (2^FRAC_BITS / d) plus the rounded quotient of the small remainder term.
  localparam int REAL_DIV  = 40;
  localparam int IMAG_DIV  = 25;
  localparam int REAL_Q    = (1 << FRAC_BITS) / REAL_DIV;
  localparam int REAL_R    = (1 << FRAC_BITS) % REAL_DIV;
  localparam int IMAG_Q    = (1 << FRAC_BITS) / IMAG_DIV;
  localparam int IMAG_R    = (1 << FRAC_BITS) % IMAG_DIV;
  localparam int REAL_HALF = REAL_DIV / 2;
  localparam int IMAG_HALF = IMAG_DIV / 2;

  // Reciprocals for the remainder term, exact for 14-bit dividends.
  localparam logic [15:0] RECIP_40       = 16'd52429;
  localparam int          RECIP_40_SHIFT = 21;
  localparam logic [15:0] RECIP_25       = 16'd41944;
  localparam int          RECIP_25_SHIFT = 20;

  typedef struct packed {
    logic [7:0] row;
    logic [7:0] col;
  } in_item_t;

  typedef struct packed {
    logic       escaped;
    logic [7:0] iterations;
    logic [6:0] glyph;
  } out_item_t;

  // Request from the port logic to the iteration core.
  typedef struct packed {
    logic       go;
    in_item_t   item;
    logic [7:0] limit;
    logic [6:0] radius;
  } mbe_req_t;

  // Magnitude of a Q8 value; the most negative value maps to 2^(W-1).
  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    logic [W-1:0] u;
    u = v;
    return v[W-1] ? (~u + W'(1)) : u;
  endfunction

  // Real part: (20 - col) * 2^FRAC_BITS / 40, rounded half away from zero.
  function automatic logic [W-1:0] map_real(input logic [7:0] col);
    logic        neg;
    logic [7:0]  ak;
    logic [13:0] x;
    logic [29:0] xp;
    logic [W-1:0] q;
    neg = (col > 8'd20);
    ak  = neg ? (col - 8'd20) : (8'd20 - col);
    x   = 14'(14'(ak) * 14'(REAL_R)) + 14'(REAL_HALF);
    xp  = 30'(x) * 30'(RECIP_40);
    q   = W'(W'(ak) * W'(REAL_Q)) + W'(xp[29:RECIP_40_SHIFT]);
    return neg ? (~q + W'(1)) : q;
  endfunction

  // Imaginary part: (2*row - 25) * 2^FRAC_BITS / 25, rounded half away from zero.
  function automatic logic [W-1:0] map_imag(input logic [7:0] row);
    logic        neg;
    logic [8:0]  ak;
    logic [13:0] x;
    logic [29:0] xp;
    logic [W-1:0] q;
    neg = (row < 8'd13);
    ak  = neg ? (9'd25 - {row, 1'b0}) : ({row, 1'b0} - 9'd25);
    x   = 14'(14'(ak) * 14'(IMAG_R)) + 14'(IMAG_HALF);
    xp  = 30'(x) * 30'(RECIP_25);
    q   = W'(W'(ak) * W'(IMAG_Q)) + W'(xp[29:RECIP_25_SHIFT]);
    return neg ? (~q + W'(1)) : q;
  endfunction

endpackage

[rtl/core/mbe_mul.sv]
// Shared unsigned multiplier with a registered product.
module mbe_mul (
  input  logic                          clk,
  input  logic [mbe_pkg::W-1:0]         a,
  input  logic [mbe_pkg::W-1:0]         b,
  output logic [mbe_pkg::PROD_W-1:0]    prod_r
);

  // The product register holds payload only, so it has no reset.
  always_ff @(posedge clk) begin
    prod_r <= mbe_pkg::PROD_W'(a) * mbe_pkg::PROD_W'(b);
  end

endmodule

[rtl/core/mbe_core.sv]
// Iteration sequencer: maps the cell to a point, then runs the orbit
// through the shared multiplier, squaring, testing and updating in turn.
module mbe_core (
  input  logic               clk,
  input  logic               rst_n,
  input  mbe_pkg::mbe_req_t  req,
  output logic               busy,
  output logic               out_valid,
  output mbe_pkg::out_item_t out_data
);

  localparam int W      = mbe_pkg::W;
  localparam int SQ_W   = mbe_pkg::SQ_W;
  localparam int PROD_W = mbe_pkg::PROD_W;
  localparam int FRAC   = mbe_pkg::FRAC_BITS;
  localparam int RE_W   = SQ_W + 2;
  localparam int RI_W   = PROD_W - FRAC + 1;
  localparam int IM_W   = W + 3;
  localparam logic [RI_W-1:0] RI_LIM = RI_W'(1) << W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_SQ_R,
    ST_SQ_I,
    ST_TEST,
    ST_UPDATE
  } state_t;

  state_t               state_r, state_nxt;
  mbe_pkg::in_item_t    item_r, item_nxt;
  logic [W-1:0]         pr_r, pr_nxt;
  logic [W-1:0]         pi_r, pi_nxt;
  logic [W-1:0]         zr_r, zr_nxt;
  logic [W-1:0]         zi_r, zi_nxt;
  logic [SQ_W-1:0]      rr_r, rr_nxt;
  logic [SQ_W-1:0]      ii_r, ii_nxt;
  logic [7:0]           cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  mbe_pkg::out_item_t   out_data_r, out_data_nxt;

  logic [W-1:0]         ar, ai, mul_a, mul_b;
  logic [PROD_W-1:0]    prod;
  logic [SQ_W-1:0]      sq_now;
  logic [SQ_W:0]        m2, thresh;
  logic [7:0]           esc_count;
  logic [15:0]          tens_prod;
  logic signed [RE_W-1:0] re_sum;
  logic [W-1:0]         re_sat;
  logic [RI_W-1:0]      ri;
  logic [W:0]           ri_cl;
  logic signed [IM_W-1:0] ci, im_sum;
  logic [W-1:0]         im_sat;
  logic                 ri_neg;

  // Operand selection for the shared multiplier.
  assign ar = mbe_pkg::mag(zr_r);
  assign ai = mbe_pkg::mag(zi_r);

  always_comb begin
    case (state_r)
      ST_SQ_R: begin
        mul_a = ar;
        mul_b = ar;
      end
      ST_SQ_I: begin
        mul_a = ai;
        mul_b = ai;
      end
      ST_TEST: begin
        mul_a = ar;
        mul_b = ai;
      end
      default: begin
        mul_a = ar;
        mul_b = ar;
      end
    endcase
  end

  mbe_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  // Truncated square from the product register.
  assign sq_now = prod[PROD_W-1:FRAC];

  // Escape test on the sum of the two truncated squares.
  assign m2     = {1'b0, rr_r} + {1'b0, sq_now};
  assign thresh = (SQ_W+1)'({req.radius, {FRAC{1'b0}}});

  // Escape index and its glyph.
  assign esc_count = cnt_r - 8'd1;
  assign tens_prod = 16'(esc_count) * 16'(mbe_pkg::TENS_RECIP);

  // New real part: rr - ii + pr, saturated to the Q8 range.
  assign re_sum = $signed({2'b00, rr_r}) - $signed({2'b00, ii_r})
                + $signed({{(RE_W-W){pr_r[W-1]}}, pr_r});

  always_comb begin
    if (&re_sum[RE_W-1:W-1] || ~|re_sum[RE_W-1:W-1]) begin
      re_sat = re_sum[W-1:0];
    end else if (re_sum[RE_W-1]) begin
      re_sat = {1'b1, {(W-1){1'b0}}};
    end else begin
      re_sat = {1'b0, {(W-1){1'b1}}};
    end
  end

  // New imaginary part: signed, clamped 2*re*im plus pi, saturated.
  assign ri     = prod[PROD_W-1:FRAC-1];
  assign ri_cl  = (ri > RI_LIM) ? RI_LIM[W:0] : ri[W:0];
  assign ri_neg = zr_r[W-1] ^ zi_r[W-1];
  assign ci     = ri_neg ? -$signed({2'b00, ri_cl}) : $signed({2'b00, ri_cl});
  assign im_sum = ci + $signed({{(IM_W-W){pi_r[W-1]}}, pi_r});

  always_comb begin
    if (&im_sum[IM_W-1:W-1] || ~|im_sum[IM_W-1:W-1]) begin
      im_sat = im_sum[W-1:0];
    end else if (im_sum[IM_W-1]) begin
      im_sat = {1'b1, {(W-1){1'b0}}};
    end else begin
      im_sat = {1'b0, {(W-1){1'b1}}};
    end
  end

  // Sequencer next-state and datapath updates.
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    pr_nxt        = pr_r;
    pi_nxt        = pi_r;
    zr_nxt        = zr_r;
    zi_nxt        = zi_r;
    rr_nxt        = rr_r;
    ii_nxt        = ii_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (req.go) begin
          item_nxt  = req.item;
          state_nxt = ST_MAP;
        end
      end
      ST_MAP: begin
        pr_nxt    = mbe_pkg::map_real(item_r.col);
        pi_nxt    = mbe_pkg::map_imag(item_r.row);
        zr_nxt    = '0;
        zi_nxt    = '0;
        cnt_nxt   = 8'd0;
        state_nxt = ST_SQ_R;
      end
      ST_SQ_R: begin
        state_nxt = ST_SQ_I;
      end
      ST_SQ_I: begin
        rr_nxt    = sq_now;
        state_nxt = ST_TEST;
      end
      ST_TEST: begin
        ii_nxt = sq_now;
        if (m2 > thresh) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.escaped    = 1'b1;
          out_data_nxt.iterations = esc_count;
          out_data_nxt.glyph      = mbe_pkg::GLYPH_BASE
                                  + 7'(tens_prod[15:mbe_pkg::TENS_SHIFT]);
          state_nxt               = ST_IDLE;
        end else if (cnt_r == req.limit) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.escaped    = 1'b0;
          out_data_nxt.iterations = 8'd0;
          out_data_nxt.glyph      = mbe_pkg::GLYPH_SPACE;
          state_nxt               = ST_IDLE;
        end else begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        zr_nxt    = re_sat;
        zi_nxt    = im_sat;
        cnt_nxt   = cnt_r + 8'd1;
        state_nxt = ST_SQ_R;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, datapath and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    pr_r       <= pr_nxt;
    pi_r       <= pi_nxt;
    zr_r       <= zr_nxt;
    zi_r       <= zi_nxt;
    rr_r       <= rr_nxt;
    ii_r       <= ii_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/core/mandelbrot_escape_time_unit.sv]
// Channel  | Handshake              | Payload
// ---------+------------------------+---------------------------------------
// in       | start, busy            | in_data  (row, col)
// out      | out_valid (strobe)     | out_data (escaped, iterations, glyph)
// cfg      | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
// An accepted item first has its cell mapped to a point; the orbit is then
// squared and tested, and each update is followed by another square and test.
// The squares re^2, im^2 and the cross term re*im all run on the one shared
// 32x32 multiplier. Busy stays high from acceptance until the result strobe,
// and no new item is taken while it is high; a new transaction may start in
// the strobe cycle. Results cannot be stalled by the receiver. Reset is
// synchronous, active low.
module mandelbrot_escape_time_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mbe_pkg::in_item_t  in_data,
  output logic               out_valid,
  output mbe_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  logic [7:0]        limit_r, limit_nxt;
  logic [6:0]        radius_r, radius_nxt;
  mbe_pkg::mbe_req_t req;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_comb begin
    limit_nxt  = limit_r;
    radius_nxt = radius_r;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == mbe_pkg::CFG_ITER_LIMIT) begin
        limit_nxt = cfg_data;
      end else if (cfg_index == mbe_pkg::CFG_RADIUS_SQ) begin
        radius_nxt = cfg_data[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= mbe_pkg::ITER_LIMIT_RESET;
      radius_r <= mbe_pkg::RADIUS_SQ_RESET;
    end else begin
      limit_r  <= limit_nxt;
      radius_r <= radius_nxt;
    end
  end

  // Request to the iteration core.
  assign req.go     = start && !busy;
  assign req.item   = in_data;
  assign req.limit  = limit_r;
  assign req.radius = radius_r;

  mbe_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[rtl/core/mbe_chk.sv]
// Port-level checks on the escape-time unit.
module mbe_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input mbe_pkg::out_item_t out_data
);

  // An accepted transaction keeps the unit busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("unit not busy after an accepted transaction");

  // Busy ends exactly when the result strobe appears.
  a_fell_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // A result only follows a busy period.
  a_strobe_past: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result strobe without a preceding transaction");

  // An inside point reports a zero count and a space.
  a_inside_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.escaped |->
      out_data.iterations == 8'd0 && out_data.glyph == mbe_pkg::GLYPH_SPACE)
    else $error("inside point with a nonzero count or glyph");

endmodule

bind mandelbrot_escape_time_unit mbe_chk u_mbe_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

[bench/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Register indexes that the block has no register for.
  localparam logic [7:0] CFG_UNUSED_LOW  = 8'd2;
  localparam logic [7:0] CFG_UNUSED_HIGH = 8'd255;

  localparam int ITEMS_PER_SETTING  = 75;
  localparam int SETTINGS_PER_PHASE = 5;
  localparam int SETTLE_CYCLES      = 40;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                start     = 1'b0;
  logic                busy;
  mbe_pkg::in_item_t   in_data   = '0;
  logic                out_valid;
  mbe_pkg::out_item_t  out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [7:0]          cfg_index = '0;
  logic [7:0]          cfg_data  = '0;

  // Our copy of the register file and the results still owed by the block.
  logic [7:0]          limit_reg  = mbe_pkg::ITER_LIMIT_RESET;
  logic [6:0]          radius_reg = mbe_pkg::RADIUS_SQ_RESET;
  mbe_pkg::out_item_t  owed_results[$];
  int                  mismatch_count  = 0;
  int                  sender_idle_pct = 0;

  mandelbrot_escape_time_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // k * 2^FRAC_BITS / d, rounded to nearest with ties away from zero.
  function automatic longint scaled_offset(longint k, longint d);
    longint q;
    q = (((k < 0 ? -k : k) <<< mbe_pkg::FRAC_BITS) + d / 2) / d;
    return k < 0 ? -q : q;
  endfunction

  // Saturate to the signed Q8 range.
  function automatic longint clamp_q8(longint v);
    longint top;
    top = (longint'(1) <<< (mbe_pkg::W - 1)) - 1;
    if (v > top) return top;
    if (v < -top - 1) return -top - 1;
    return v;
  endfunction

  // Escape-time prediction for one cell under the given register values.
  function automatic mbe_pkg::out_item_t escape_time(mbe_pkg::in_item_t xy,
                                                     logic [7:0] lim,
                                                     logic [6:0] rad);
    longint             cre, cim, zr, zi, ar, ai, rr, ii, ri, thr, m2;
    int                 count;
    bit                 esc;
    mbe_pkg::out_item_t res;
    cre   = scaled_offset(20 - longint'(xy.col), 40);
    cim   = scaled_offset(2 * longint'(xy.row) - 25, 25);
    thr   = longint'(rad) <<< mbe_pkg::FRAC_BITS;
    zr    = 0;
    zi    = 0;
    esc   = 1'b0;
    count = 0;
    for (int i = 0; i < int'(lim); i++) begin
      ar = zr < 0 ? -zr : zr;
      ai = zi < 0 ? -zi : zi;
      rr = (ar * ar) >>> mbe_pkg::FRAC_BITS;
      ii = (ai * ai) >>> mbe_pkg::FRAC_BITS;
      // The cross term is clamped before the add so it cannot wrap.
      ri = (ar * ai) >>> (mbe_pkg::FRAC_BITS - 1);
      if (ri > (longint'(1) <<< mbe_pkg::W)) ri = longint'(1) <<< mbe_pkg::W;
      if ((zr < 0) != (zi < 0)) ri = -ri;
      zr = clamp_q8(rr - ii + cre);
      zi = clamp_q8(ri + cim);
      ar = zr < 0 ? -zr : zr;
      ai = zi < 0 ? -zi : zi;
      m2 = ((ar * ar) >>> mbe_pkg::FRAC_BITS) + ((ai * ai) >>> mbe_pkg::FRAC_BITS);
      if (m2 > thr) begin
        esc   = 1'b1;
        count = i;
        break;
      end
    end
    res.escaped    = esc;
    res.iterations = esc ? 8'(count) : 8'd0;
    res.glyph      = esc ? 7'(mbe_pkg::GLYPH_BASE + count / 10) : mbe_pkg::GLYPH_SPACE;
    return res;
  endfunction

  function automatic mbe_pkg::in_item_t make_cell(int r, int c);
    mbe_pkg::in_item_t xy;
    xy.row = 8'(r);
    xy.col = 8'(c);
    return xy;
  endfunction

  // Most cells land near the set, where orbits run long; the rest span the full field.
  function automatic mbe_pkg::in_item_t random_cell();
    mbe_pkg::in_item_t xy;
    if ($urandom_range(99) < 60) begin
      xy.row = 8'($urandom_range(26));
      xy.col = 8'($urandom_range(100));
    end else begin
      xy = 16'($urandom);
    end
    return xy;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Send one cell, idling first at the current rate; the transaction is
  // taken at the first edge that sees start high and busy low.
  task automatic send_cell(mbe_pkg::in_item_t xy);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    start   <= 1'b1;
    in_data <= xy;
    do @(posedge clk); while (busy);
    owed_results.push_back(escape_time(xy, limit_reg, radius_reg));
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == mbe_pkg::CFG_ITER_LIMIT) limit_reg = val;
    else if (idx == mbe_pkg::CFG_RADIUS_SQ) radius_reg = val[6:0];
    @(posedge clk);
  endtask

  // Registers change only with nothing in flight.
  task automatic set_config(logic [7:0] lim, logic [7:0] rad);
    wait_drain();
    write_reg(mbe_pkg::CFG_ITER_LIMIT, lim);
    write_reg(mbe_pkg::CFG_RADIUS_SQ, rad);
  endtask

  // Check every result strobe against the oldest owed result.
  always @(posedge clk) begin : check_results
    mbe_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (owed_results.size() == 0) begin
        flag_mismatch("result strobe with no transaction outstanding");
      end else begin
        want = owed_results.pop_front();
        if (out_data.escaped !== want.escaped)
          flag_mismatch($sformatf("escaped %0b, want %0b", out_data.escaped, want.escaped));
        if (out_data.iterations !== want.iterations)
          flag_mismatch($sformatf("iterations %0d, want %0d",
                                  out_data.iterations, want.iterations));
        if (out_data.glyph !== want.glyph)
          flag_mismatch($sformatf("glyph %0d, want %0d", out_data.glyph, want.glyph));
      end
    end
  end

  // Field corners and points in and near the set, under the reset register values.
  task automatic test_reset_defaults();
    send_cell(make_cell(0, 0));
    send_cell(make_cell(255, 255));
    send_cell(make_cell(0, 255));
    send_cell(make_cell(255, 0));
    send_cell(make_cell(12, 20));
    send_cell(make_cell(13, 60));
  endtask

  // Smallest and largest limit, and a zero limit that runs no iterations.
  task automatic test_limit_extremes();
    logic [7:0] lims[3] = '{8'd1, 8'd255, 8'd0};
    foreach (lims[k]) begin
      set_config(lims[k], 8'(mbe_pkg::RADIUS_SQ_RESET));
      send_cell(make_cell(12, 20));
      send_cell(make_cell(5, 30));
    end
  endtask

  // Smallest and largest radius, and a zero radius where any nonzero orbit
  // escapes; the last write also sets the unused top data bit.
  task automatic test_radius_extremes();
    logic [7:0] rads[3] = '{8'd1, 8'd127, 8'h80};
    foreach (rads[k]) begin
      set_config(8'd250, rads[k]);
      send_cell(make_cell(12, 20));
      send_cell(make_cell(20, 10));
    end
  endtask

  // Writes to an index with no register must leave both registers alone.
  task automatic test_unknown_register();
    set_config(8'd40, 8'd9);
    write_reg(CFG_UNUSED_LOW, 8'hff);
    write_reg(CFG_UNUSED_HIGH, 8'h01);
    send_cell(make_cell(12, 40));
    send_cell(make_cell(3, 70));
  endtask

  // The sender waits for every owed result before each transaction.
  task automatic test_pause_until_drained();
    set_config(8'd60, 8'd4);
    sender_idle_pct = 0;
    repeat (10) begin
      send_cell(random_cell());
      wait_drain();
    end
  endtask

  // Random cells under random settings, through each sender idling rate.
  // The receiver cannot stall, so its stall phase runs like the no-idle one.
  task automatic test_random_phases();
    int pcts[4] = '{0, 85, 0, 17};
    logic [7:0] lim;
    foreach (pcts[p]) begin
      sender_idle_pct = pcts[p];
      repeat (SETTINGS_PER_PHASE) begin
        lim = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 64));
        set_config(lim, 8'($urandom));
        repeat (ITEMS_PER_SETTING) send_cell(random_cell());
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_limit_extremes();
    test_radius_extremes();
    test_unknown_register();
    test_pause_until_drained();
    test_random_phases();
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #80_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

[sim.f]
rtl/core/mbe_pkg.sv
rtl/core/mbe_mul.sv
rtl/core/mbe_core.sv
rtl/core/mandelbrot_escape_time_unit.sv
rtl/core/mbe_chk.sv
bench/tb.sv
